FILE: rtl/json_string_unescape_utf8_defines.svh
// Assertion helpers shared by the checker files.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Checked only outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset as well.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/jsu_pkg.sv
package jsu_pkg;

  // Result slots one input byte can produce (pending surrogate plus a code point)
  localparam int BURST_MAX = 6;
  // Longest UTF-8 sequence
  localparam int TAIL_MAX  = 4;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_UNTERM   = 3'd2,
    ST_BAD_HEX  = 3'd3,
    ST_BAD_ESC  = 3'd4
  } status_t;

  // One result byte
  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } res_t;

  // Up to one UTF-8 sequence
  typedef struct packed {
    res_t [TAIL_MAX-1:0] r;
    logic [2:0]          n;
  } tail_t;

  // Everything one input byte produces, in transfer order from slot 0
  typedef struct packed {
    res_t [BURST_MAX-1:0] slot;
    logic [2:0]           cnt;
  } burst_t;

  // UTF-8 encode of a code point up to 21 bits
  function automatic tail_t utf8_tail(logic [20:0] cp);
    tail_t t;
    t = '0;
    for (int i = 0; i < TAIL_MAX; i++) begin
      t.r[i].status = ST_DATA;
      t.r[i].last   = 1'b0;
    end
    if (cp < 21'h80) begin
      t.r[0].data = cp[7:0];
      t.n = 3'd1;
    end else if (cp < 21'h800) begin
      t.r[0].data = {3'b110, cp[10:6]};
      t.r[1].data = {2'b10, cp[5:0]};
      t.n = 3'd2;
    end else if (cp < 21'h10000) begin
      t.r[0].data = {4'b1110, cp[15:12]};
      t.r[1].data = {2'b10, cp[11:6]};
      t.r[2].data = {2'b10, cp[5:0]};
      t.n = 3'd3;
    end else begin
      t.r[0].data = {5'b11110, cp[20:18]};
      t.r[1].data = {2'b10, cp[17:12]};
      t.r[2].data = {2'b10, cp[11:6]};
      t.r[3].data = {2'b10, cp[5:0]};
      t.n = 3'd4;
    end
    return t;
  endfunction

endpackage

FILE: rtl/jsu_decode.sv
// Input register, escape/surrogate decoder state, and the per-byte result burst.
module jsu_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      char_byte,
  input  logic            begin_req,
  input  logic            can_load,
  output logic            load,
  output jsu_pkg::burst_t burst
);

  typedef enum logic [2:0] {
    M_IDLE, M_TEXT, M_ESC, M_HEX, M_PEND_BS, M_PEND_U, M_PEND_HEX
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  // Input register
  logic       held;
  logic [7:0] c_q;
  logic       beg_q;

  // Decoder state
  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [9:0]  pend, pend_next;   // low ten bits of the held high surrogate

  // Effective state after a begin flag
  mode_t       em;
  logic [1:0]  cnt_e;
  logic [15:0] acc_e;

  logic          txt_emit;
  jsu_pkg::res_t txt_res;
  mode_t         txt_mode;
  logic          esc_emit;
  jsu_pkg::res_t esc_res;
  mode_t         esc_mode;

  logic        hv;
  logic [3:0]  hd;
  logic [15:0] acc_new;
  logic [20:0] pair_cp;
  logic        pre;
  jsu_pkg::tail_t pre_t, tail;

  function automatic jsu_pkg::tail_t single(jsu_pkg::res_t r);
    jsu_pkg::tail_t t;
    t = '0;
    t.r[0] = r;
    t.n = 3'd1;
    return t;
  endfunction

  function automatic jsu_pkg::res_t mk(logic [7:0] d, jsu_pkg::status_t s, logic l);
    jsu_pkg::res_t r;
    r.data = d;
    r.status = s;
    r.last = l;
    return r;
  endfunction

  assign load     = held && can_load;
  assign in_ready = !held || can_load;

  assign em    = beg_q ? M_TEXT : mode;
  assign cnt_e = beg_q ? 2'd0 : hex_count;
  assign acc_e = beg_q ? 16'd0 : hex_accum;

  // Plain text byte
  always_comb begin
    txt_emit = 1'b1;
    txt_res  = mk(c_q, jsu_pkg::ST_DATA, 1'b0);
    txt_mode = M_TEXT;
    if (c_q == CH_QUOTE) begin
      txt_res  = mk(8'h00, jsu_pkg::ST_COMPLETE, 1'b1);
      txt_mode = M_IDLE;
    end else if (c_q == 8'h00) begin
      txt_res  = mk(8'h00, jsu_pkg::ST_UNTERM, 1'b1);
      txt_mode = M_IDLE;
    end else if (c_q == CH_BSL) begin
      txt_emit = 1'b0;
      txt_mode = M_ESC;
    end
  end

  // Byte after a backslash
  always_comb begin
    esc_emit = 1'b1;
    esc_res  = mk(c_q, jsu_pkg::ST_DATA, 1'b0);
    esc_mode = M_TEXT;
    case (c_q)
      CH_QUOTE, CH_BSL, CH_SLASH: ;
      8'h62: esc_res.data = 8'h08;
      8'h66: esc_res.data = 8'h0C;
      8'h6E: esc_res.data = 8'h0A;
      8'h72: esc_res.data = 8'h0D;
      8'h74: esc_res.data = 8'h09;
      CH_U: begin
        esc_emit = 1'b0;
        esc_mode = M_HEX;
      end
      default: begin
        esc_res  = mk(8'h00, jsu_pkg::ST_BAD_ESC, 1'b1);
        esc_mode = M_IDLE;
      end
    endcase
  end

  // Hex digit value
  always_comb begin
    hv = 1'b1;
    hd = 4'd0;
    if (c_q inside {[8'h30:8'h39]}) begin
      hd = c_q[3:0];
    end else if (c_q inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hd = 4'(c_q[3:0] + 4'd9);
    end else begin
      hv = 1'b0;
    end
  end

  assign acc_new = {acc_e[11:0], hd};
  assign pair_cp = 21'h10000 + {1'b0, pend, acc_new[9:0]};
  assign pre_t   = jsu_pkg::utf8_tail({5'b0, 6'b110110, pend});

  // Next state and results for the held byte
  always_comb begin
    mode_next      = em;
    hex_count_next = cnt_e;
    hex_accum_next = acc_e;
    pend_next      = pend;
    pre            = 1'b0;
    tail           = '0;
    case (em)
      M_IDLE: ;
      M_TEXT: begin
        mode_next = txt_mode;
        if (txt_emit) begin
          tail = single(txt_res);
        end
      end
      M_ESC: begin
        mode_next = esc_mode;
        if (esc_emit) begin
          tail = single(esc_res);
        end else begin
          hex_count_next = 2'd0;
          hex_accum_next = 16'd0;
        end
      end
      M_HEX, M_PEND_HEX: begin
        if (!hv) begin
          pre            = (em == M_PEND_HEX);
          tail           = single(mk(8'h00, jsu_pkg::ST_BAD_HEX, 1'b1));
          mode_next      = M_IDLE;
          hex_count_next = 2'd0;
          hex_accum_next = 16'd0;
        end else if (cnt_e != 2'd3) begin
          hex_count_next = 2'(cnt_e + 2'd1);
          hex_accum_next = acc_new;
        end else begin
          hex_count_next = 2'd0;
          hex_accum_next = acc_new;
          if (em == M_PEND_HEX && acc_new[15:10] == 6'b110111) begin
            // valid pair
            tail      = jsu_pkg::utf8_tail(pair_cp);
            mode_next = M_TEXT;
          end else begin
            pre = (em == M_PEND_HEX);
            if (acc_new[15:10] == 6'b110110) begin
              pend_next = acc_new[9:0];
              mode_next = M_PEND_BS;
            end else begin
              tail      = jsu_pkg::utf8_tail({5'b0, acc_new});
              mode_next = M_TEXT;
            end
          end
        end
      end
      M_PEND_BS: begin
        if (c_q == CH_BSL) begin
          mode_next = M_PEND_U;
        end else begin
          pre       = 1'b1;
          mode_next = txt_mode;
          if (txt_emit) begin
            tail = single(txt_res);
          end
        end
      end
      M_PEND_U: begin
        if (c_q == CH_U) begin
          mode_next      = M_PEND_HEX;
          hex_count_next = 2'd0;
          hex_accum_next = 16'd0;
        end else begin
          pre       = 1'b1;
          mode_next = esc_mode;
          if (esc_emit) begin
            tail = single(esc_res);
          end
        end
      end
      default: mode_next = M_IDLE;
    endcase
  end

  // Pack prefix (unpaired high surrogate) and tail into the burst
  always_comb begin
    burst = '0;
    if (pre) begin
      for (int i = 0; i < 3; i++) begin
        burst.slot[i]     = pre_t.r[i];
        burst.slot[i + 3] = tail.r[i];
      end
      burst.cnt = 3'(3'd3 + tail.n);
    end else begin
      for (int i = 0; i < jsu_pkg::TAIL_MAX; i++) begin
        burst.slot[i] = tail.r[i];
      end
      burst.cnt = tail.n;
    end
  end

  // State and input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      mode      <= M_IDLE;
      hex_count <= 2'd0;
      hex_accum <= 16'd0;
      pend      <= 10'd0;
    end else begin
      if (load) begin
        mode      <= mode_next;
        hex_count <= hex_count_next;
        hex_accum <= hex_accum_next;
        pend      <= pend_next;
      end
      if (in_valid && in_ready) begin
        held <= 1'b1;
      end else if (load) begin
        held <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      c_q   <= char_byte;
      beg_q <= begin_req;
    end
  end

endmodule

FILE: rtl/jsu_burst.sv
// Result buffer: holds one burst and presents it one byte per transfer.
module jsu_burst (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jsu_pkg::burst_t burst,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output jsu_pkg::res_t   head
);

  jsu_pkg::res_t [jsu_pkg::BURST_MAX-1:0] slot;
  logic [2:0] rem;
  logic [2:0] idx;
  logic       pop;

  assign out_valid = (rem != 3'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (rem == 3'd0) || (rem == 3'd1 && out_ready);
  assign head      = slot[idx];

  // Load a new burst or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      idx <= 3'd0;
    end else if (load) begin
      rem <= burst.cnt;
      idx <= 3'd0;
    end else if (pop) begin
      rem <= 3'(rem - 3'd1);
      idx <= 3'(idx + 3'd1);
    end
    if (load) begin
      slot <= burst.slot;
    end
  end

endmodule

FILE: rtl/json_string_unescape_utf8.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------
// input    | in_valid / in_ready  | char_byte, begin_req
// output   | out_valid / out_ready| out_byte, status, last
//
// One byte is taken per cycle while in_ready is high; it waits in the input
// register, then its 0 to 6 result bytes load into the result buffer at once.
// Output drains one byte per cycle while out_ready is high; a byte with several
// results holds the input register; single-byte results sustain one per cycle.
// Reset (rst, synchronous) empties both registers and sets the decoder idle.
// Output stalls back up through the result buffer to the input register.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       begin_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] status,
  output logic       last
);

  jsu_pkg::burst_t burst;
  jsu_pkg::res_t   head;
  logic            load;
  logic            can_load;

  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_byte (char_byte),
    .begin_req (begin_req),
    .can_load  (can_load),
    .load      (load),
    .burst     (burst)
  );

  jsu_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte = head.data;
  assign status   = head.status;
  assign last     = head.last;

endmodule

FILE: rtl/jsu_checker.sv
`include "json_string_unescape_utf8_defines.svh"

// Port-level checks on the unescaper.
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] char_byte,
  input logic       begin_req,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [2:0] status,
  input logic       last
);

  // Channel payloads as single words, and stall conditions
  logic [8:0]  in_word;
  logic [11:0] res_word;
  logic        in_stall;
  logic        out_stall;
  logic        data_res;

  assign in_word   = {char_byte, begin_req};
  assign res_word  = {out_byte, status, last};
  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;
  assign data_res  = (status == jsu_pkg::ST_DATA);

  // A waiting input transfer holds
  `JSU_ASSERT(a_in_hold, in_stall |=> in_valid && $stable(in_word), "stalled input changed")

  // A stalled result holds
  `JSU_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(res_word), "stalled result changed")

  // Last marks exactly the non-data results
  `JSU_ASSERT(a_last_status, out_valid |-> (last == !data_res), "last and status disagree")

  // Terminator and errors carry a zero byte
  `JSU_ASSERT(a_last_zero, out_valid && last |-> out_byte == 8'h00, "final result not zero")

  // Nothing comes out right after reset
  `JSU_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "output valid after reset")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
